FILE: hdl/tld_pkg.sv
// shared types and constants for the template list discovery block
// no dependencies; imported by tld_front, tld_engine and template_list_discovery
`default_nettype none

package tld_pkg;

    // stream widths, fields packed from the lowest bit up
    localparam int S_TDATA_W = 104;
    localparam int S_TUSER_W = 5;
    localparam int M_TDATA_W = 144;
    localparam int M_TUSER_W = 4;

    // incoming token classes
    localparam logic [3:0] CLS_TRIVIA   = 4'd1;
    localparam logic [3:0] CLS_IDENT    = 4'd2;
    localparam logic [3:0] CLS_LESS     = 4'd3;
    localparam logic [3:0] CLS_GT       = 4'd5;
    localparam logic [3:0] CLS_GTGT     = 4'd6;
    localparam logic [3:0] CLS_GTEQ     = 4'd7;
    localparam logic [3:0] CLS_GTGTEQ   = 4'd8;
    localparam logic [3:0] CLS_OPEN     = 4'd9;
    localparam logic [3:0] CLS_CLOSE    = 4'd10;
    localparam logic [3:0] CLS_BOUNDARY = 4'd11;
    localparam logic [3:0] CLS_LOGIC    = 4'd12;
    localparam logic [3:0] CLS_EQUAL    = 4'd13;

    // operation the back end carries out for a token
    typedef enum logic [3:0] {
        OP_OTHER,
        OP_TRIVIA,
        OP_IDENT,
        OP_LESS,
        OP_GT,
        OP_GTGT,
        OP_GTEQ,
        OP_GTGTEQ,
        OP_OPEN,
        OP_CLOSE,
        OP_RESET,
        OP_LOGIC
    } op_t;

    // output tags
    localparam logic [2:0] TAG_RAW     = 3'd0;
    localparam logic [2:0] TAG_TSTART  = 3'd1;
    localparam logic [2:0] TAG_TEND    = 3'd2;
    localparam logic [2:0] TAG_GREATER = 3'd3;
    localparam logic [2:0] TAG_EQUAL   = 3'd4;
    localparam logic [2:0] TAG_GEQUAL  = 3'd5;

    // record kinds
    localparam logic REC_TOKEN = 1'b0;
    localparam logic REC_RETAG = 1'b1;

    typedef struct packed {
        logic        start;
        op_t         op;
        logic [7:0]  code;
        logic [31:0] offset;
        logic [31:0] length;
        logic [31:0] column;
    } item_t;

    typedef struct packed {
        logic        kind;
        logic [2:0]  tag;
        logic [7:0]  raw;
        logic [31:0] position;
        logic [31:0] offset;
        logic [31:0] length;
        logic [31:0] column;
        logic        ovf;
        logic        last;
    } record_t;

endpackage

`default_nettype wire

FILE: hdl/tld_front.sv
// front end: accepts tokens, decodes the class into an operation and queues them
// depends on tld_pkg
`default_nettype none

module tld_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // token_code, offset, length, column
    input  logic [tld_pkg::S_TDATA_W-1:0]   s_tdata,
    // stream_start, token_class
    input  logic [tld_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                            q_valid,
    input  logic                            q_ready,
    output tld_pkg::item_t                  q_item
);
    import tld_pkg::*;

    item_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    item_t      in_item;
    logic [3:0] cls;
    logic       push;
    logic       pop;

    always_comb begin
        cls = s_tuser[4:1];
        in_item.start  = s_tuser[0];
        in_item.code   = s_tdata[7:0];
        in_item.offset = s_tdata[39:8];
        in_item.length = s_tdata[71:40];
        in_item.column = s_tdata[103:72];
        unique case (cls) inside
            CLS_TRIVIA:             in_item.op = OP_TRIVIA;
            CLS_IDENT:              in_item.op = OP_IDENT;
            CLS_LESS:               in_item.op = OP_LESS;
            CLS_GT:                 in_item.op = OP_GT;
            CLS_GTGT:               in_item.op = OP_GTGT;
            CLS_GTEQ:               in_item.op = OP_GTEQ;
            CLS_GTGTEQ:             in_item.op = OP_GTGTEQ;
            CLS_OPEN:               in_item.op = OP_OPEN;
            CLS_CLOSE:              in_item.op = OP_CLOSE;
            CLS_BOUNDARY, CLS_EQUAL: in_item.op = OP_RESET;
            CLS_LOGIC:              in_item.op = OP_LOGIC;
            default:                in_item.op = OP_OTHER;
        endcase
    end

    assign s_tready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = entry_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hdl/tld_engine.sv
// back end: candidate stack, nesting level and record sequencer
// depends on tld_pkg; fed by tld_front
`default_nettype none

module tld_engine #(
    parameter int STACK_ENTRIES = 256,
    parameter int INDEX_BITS    = 32,
    parameter int DEPTH_BITS    = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    output logic             q_ready,
    input  tld_pkg::item_t   q_item,
    output logic             m_valid,
    input  logic             m_ready,
    output tld_pkg::record_t m_rec
);
    import tld_pkg::*;

    localparam int CW = $clog2(STACK_ENTRIES + 1);
    localparam int AW = (STACK_ENTRIES > 1) ? $clog2(STACK_ENTRIES) : 1;
    localparam logic [CW-1:0] STACK_FULL = CW'(STACK_ENTRIES);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD,
        ST_RETAG,
        ST_SECOND,
        ST_TAIL,
        ST_POP
    } state_t;

    state_t                state_reg,    state_next;
    item_t                 item_reg,     item_next;
    logic                  part_reg,     part_next;
    logic [CW-1:0]         cnt_reg,      cnt_next;
    logic [DEPTH_BITS-1:0] nest_reg,     nest_next;
    logic                  ident_reg,    ident_next;
    logic                  ovf_rep_reg,  ovf_rep_next;
    logic [INDEX_BITS-1:0] emit_cnt_reg, emit_cnt_next;
    logic                  out_valid_reg, out_valid_next;
    record_t               out_rec_reg,  out_rec_next;

    logic [INDEX_BITS-1:0] mem_pos   [STACK_ENTRIES];
    logic [DEPTH_BITS-1:0] mem_depth [STACK_ENTRIES];
    logic [INDEX_BITS-1:0] rd_pos_reg;
    logic [DEPTH_BITS-1:0] rd_depth_reg;

    logic          push_en;
    logic [CW-1:0] top_cnt;
    logic [AW-1:0] rd_addr;
    logic          out_free;
    logic          top_match;
    logic          pop_hit;
    record_t       tok_rec;
    record_t       retag_rec;
    logic [31:0]   off1, off2, col1, col2;

    assign out_free  = !out_valid_reg || m_ready;
    assign top_match = (cnt_reg != '0) && (rd_depth_reg == nest_reg);
    assign pop_hit   = (cnt_reg != '0) && (rd_depth_reg >= nest_reg);
    assign off1 = item_reg.offset + 32'd1;
    assign off2 = item_reg.offset + 32'd2;
    assign col1 = item_reg.column + 32'd1;
    assign col2 = item_reg.column + 32'd2;

    // top of the stack as it stands after this cycle, read into rd_pos_reg and rd_depth_reg
    assign top_cnt = cnt_next - CW'(1);
    assign rd_addr = top_cnt[AW-1:0];

    always_comb begin
        tok_rec.kind     = REC_TOKEN;
        tok_rec.tag      = TAG_RAW;
        tok_rec.raw      = item_reg.code;
        tok_rec.position = 32'(emit_cnt_reg);
        tok_rec.offset   = item_reg.offset;
        tok_rec.length   = item_reg.length;
        tok_rec.column   = item_reg.column;
        tok_rec.ovf      = 1'b0;
        tok_rec.last     = 1'b0;

        retag_rec.kind     = REC_RETAG;
        retag_rec.tag      = TAG_TSTART;
        retag_rec.raw      = 8'd0;
        retag_rec.position = 32'(rd_pos_reg);
        retag_rec.offset   = 32'd0;
        retag_rec.length   = 32'd0;
        retag_rec.column   = 32'd0;
        retag_rec.ovf      = 1'b0;
        retag_rec.last     = 1'b0;
    end

    always_comb begin
        state_next     = state_reg;
        item_next      = item_reg;
        part_next      = part_reg;
        cnt_next       = cnt_reg;
        nest_next      = nest_reg;
        ident_next     = ident_reg;
        ovf_rep_next   = ovf_rep_reg;
        emit_cnt_next  = emit_cnt_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_rec_next   = out_rec_reg;
        push_en        = 1'b0;
        q_ready        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    item_next  = q_item;
                    part_next  = 1'b0;
                    state_next = ST_HEAD;
                    if (q_item.start) begin
                        cnt_next      = '0;
                        nest_next     = '0;
                        ident_next    = 1'b0;
                        ovf_rep_next  = 1'b0;
                        emit_cnt_next = '0;
                    end
                end
            end

            ST_HEAD: begin
                if (out_free) begin
                    out_rec_next      = tok_rec;
                    out_rec_next.last = 1'b1;
                    out_valid_next    = 1'b1;
                    emit_cnt_next     = emit_cnt_reg + INDEX_BITS'(1);
                    state_next        = ST_IDLE;
                    if (item_reg.op != OP_TRIVIA) begin
                        ident_next = (item_reg.op == OP_IDENT);
                    end
                    unique case (item_reg.op) inside
                        OP_LESS: begin
                            if (ident_reg) begin
                                if (cnt_reg < STACK_FULL) begin
                                    push_en  = 1'b1;
                                    cnt_next = cnt_reg + CW'(1);
                                end else if (!ovf_rep_reg) begin
                                    ovf_rep_next     = 1'b1;
                                    out_rec_next.ovf = 1'b1;
                                end
                            end
                        end
                        OP_GT, OP_GTGT, OP_GTEQ, OP_GTGTEQ: begin
                            if (top_match) begin
                                out_rec_next.tag  = TAG_TEND;
                                out_rec_next.last = 1'b0;
                                if (item_reg.op != OP_GT) begin
                                    out_rec_next.length = 32'd1;
                                end
                                state_next = ST_RETAG;
                            end
                        end
                        OP_OPEN: begin
                            if (nest_reg != '1) begin
                                nest_next = nest_reg + DEPTH_BITS'(1);
                            end
                        end
                        OP_CLOSE, OP_LOGIC: begin
                            state_next = ST_POP;
                        end
                        OP_RESET: begin
                            cnt_next  = '0;
                            nest_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_RETAG: begin
                if (out_free) begin
                    out_rec_next   = retag_rec;
                    out_valid_next = 1'b1;
                    cnt_next       = cnt_reg - CW'(1);
                    state_next     = ST_IDLE;
                    unique case (item_reg.op) inside
                        OP_GTEQ: state_next = ST_TAIL;
                        OP_GTGT: begin
                            if (part_reg) begin
                                out_rec_next.last = 1'b1;
                            end else begin
                                state_next = ST_SECOND;
                            end
                        end
                        OP_GTGTEQ: state_next = part_reg ? ST_TAIL : ST_SECOND;
                        default: out_rec_next.last = 1'b1;
                    endcase
                end
            end

            ST_SECOND: begin
                if (out_free) begin
                    out_rec_next        = tok_rec;
                    out_rec_next.offset = off1;
                    out_rec_next.column = col1;
                    out_rec_next.length = 32'd1;
                    out_valid_next      = 1'b1;
                    emit_cnt_next       = emit_cnt_reg + INDEX_BITS'(1);
                    if (top_match) begin
                        out_rec_next.tag = TAG_TEND;
                        part_next        = 1'b1;
                        state_next       = ST_RETAG;
                    end else begin
                        out_rec_next.last = 1'b1;
                        state_next        = ST_IDLE;
                        if (item_reg.op == OP_GTGT) begin
                            out_rec_next.tag = TAG_GREATER;
                        end else begin
                            out_rec_next.tag    = TAG_GEQUAL;
                            out_rec_next.length = 32'd2;
                        end
                    end
                end
            end

            ST_TAIL: begin
                if (out_free) begin
                    out_rec_next        = tok_rec;
                    out_rec_next.tag    = TAG_EQUAL;
                    out_rec_next.length = 32'd1;
                    out_rec_next.last   = 1'b1;
                    out_rec_next.offset = (item_reg.op == OP_GTGTEQ) ? off2 : off1;
                    out_rec_next.column = (item_reg.op == OP_GTGTEQ) ? col2 : col1;
                    out_valid_next      = 1'b1;
                    emit_cnt_next       = emit_cnt_reg + INDEX_BITS'(1);
                    cnt_next            = '0;
                    nest_next           = '0;
                    state_next          = ST_IDLE;
                end
            end

            ST_POP: begin
                // one candidate at or above the current level per pass
                if (pop_hit) begin
                    cnt_next = cnt_reg - CW'(1);
                end else begin
                    if (item_reg.op == OP_CLOSE && nest_reg != '0) begin
                        nest_next = nest_reg - DEPTH_BITS'(1);
                    end
                    state_next = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push_en) begin
            mem_pos[cnt_reg[AW-1:0]]   <= emit_cnt_reg;
            mem_depth[cnt_reg[AW-1:0]] <= nest_reg;
        end
        rd_pos_reg   <= mem_pos[rd_addr];
        rd_depth_reg <= mem_depth[rd_addr];
    end

    always_ff @(posedge aclk) begin
        item_reg    <= item_next;
        out_rec_reg <= out_rec_next;
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            part_reg      <= 1'b0;
            cnt_reg       <= '0;
            nest_reg      <= '0;
            ident_reg     <= 1'b0;
            ovf_rep_reg   <= 1'b0;
            emit_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            part_reg      <= part_next;
            cnt_reg       <= cnt_next;
            nest_reg      <= nest_next;
            ident_reg     <= ident_next;
            ovf_rep_reg   <= ovf_rep_next;
            emit_cnt_reg  <= emit_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_rec   = out_rec_reg;

endmodule

`default_nettype wire

FILE: hdl/template_list_discovery.sv
// template list discovery top level: front end, token queue and back-end sequencer
// depends on tld_pkg, tld_front and tld_engine
//
//  channel   direction  carries
//  s_*       in         one classified token per transaction
//  m_*       out        one emitted token or retag record per transaction
//
// a plain token is taken from the queue in ST_IDLE and emitted in ST_HEAD
// each extra record of a split closer is emitted from ST_RETAG, ST_SECOND or ST_TAIL
// close or logical tokens pop candidates one at a time in ST_POP: one stack read port
// reset is synchronous; the candidate stack is not cleared, only its count
// a stalled output holds the sequencer; the two-entry queue accepts input until full
`default_nettype none

module template_list_discovery #(
    parameter int STACK_ENTRIES = 256,
    parameter int INDEX_BITS    = 32,
    parameter int DEPTH_BITS    = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // token_code, offset, length, column
    input  logic [tld_pkg::S_TDATA_W-1:0] s_tdata,
    // stream_start, token_class
    input  logic [tld_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // raw_kind, position, token_offset, token_length, token_column, nesting_overflow, zero pad
    output logic [tld_pkg::M_TDATA_W-1:0] m_tdata,
    // record_kind, tag
    output logic [tld_pkg::M_TUSER_W-1:0] m_tuser,
    output logic                          m_tlast
);
    import tld_pkg::*;

    logic    q_valid;
    logic    q_ready;
    item_t   q_item;
    record_t rec;

    tld_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    tld_engine #(
        .STACK_ENTRIES (STACK_ENTRIES),
        .INDEX_BITS    (INDEX_BITS),
        .DEPTH_BITS    (DEPTH_BITS)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_rec   (rec)
    );

    assign m_tdata = {7'd0, rec.ovf, rec.column, rec.length, rec.offset, rec.position, rec.raw};
    assign m_tuser = {rec.tag, rec.kind};
    assign m_tlast = rec.last;

endmodule

`default_nettype wire
